// ===== rtl/uabt_pkg.sv =====
package uabt_pkg;

  // Default graph size and the fixed field widths.
  localparam int MAX_NODES_DEF = 64;
  localparam int NODE_W        = 6;
  localparam int NCNT_W        = 7;
  localparam int PROD_W        = 14;
  localparam int RESULT_CAP    = 64;
  localparam int CNT_W         = 7;
  localparam int PADDR_W       = 2;
  localparam int PDATA_W       = 32;

  localparam logic [NCNT_W-1:0]  NODE_COUNT_RST  = 7'd64;
  localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = 2'd0;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_QRD,
    ST_LIST,
    ST_LCHK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [NODE_W-1:0] neighbour;
    logic              last;
  } res_t;

  // Memory request from the sequencer (address travels separately).
  typedef struct packed {
    logic en;
    logic we;
    logic wdata;
  } mem_req_t;

endpackage

// ===== rtl/uabt_mem.sv =====
module uabt_mem
  import uabt_pkg::*;
#(
  parameter int DEPTH = MAX_NODES_DEF * (MAX_NODES_DEF + 1) / 2,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  mem_req_t      req_i,
  input  logic [AW-1:0] addr_i,
  output logic          rdata_o
);

  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[addr_i] <= req_i.wdata;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/uabt_cfg.sv =====
module uabt_cfg
  import uabt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [NCNT_W-1:0]  node_count_o
);

  logic [NCNT_W-1:0] node_count_q;
  logic              wr_en;

  assign wr_en = psel && penable && pwrite && (paddr == ADDR_NODE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (wr_en) begin
      node_count_q <= pwdata[NCNT_W-1:0];
    end
  end

  assign prdata       = (paddr == ADDR_NODE_COUNT) ? PDATA_W'(node_count_q) : '0;
  assign pready       = 1'b1;
  assign node_count_o = node_count_q;

endmodule

// ===== rtl/uabt_ctrl.sv =====
module uabt_ctrl
  import uabt_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int DEPTH     = MAX_NODES * (MAX_NODES + 1) / 2,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NCNT_W-1:0] node_count_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output res_t              out_o,
  output mem_req_t          mem_req_o,
  output logic [AW-1:0]     mem_addr_o,
  input  logic              mem_rdata_i
);

  state_e state_q, state_d;

  logic [NCNT_W-1:0] n_eff;
  logic              accept;
  logic              oob;
  logic              out_free;

  cmd_e              cmd_q, cmd_d;
  logic [NODE_W-1:0] r_q, r_d;
  logic [NODE_W-1:0] c_q, c_d;
  logic [PROD_W-1:0] p1_q, p1_d;
  logic [PROD_W-1:0] p2_q, p2_d;
  logic [PROD_W-1:0] base_q, base_d;
  logic [NCNT_W-1:0] k_q, k_d;
  logic [NODE_W-1:0] pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]     clr_q, clr_d;
  res_t              res_q, res_d;

  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  logic [NCNT_W-1:0] col_max;
  logic [PROD_W-1:0] edit_idx;
  logic [PROD_W-1:0] list_idx;
  logic              k_end;

  // Effective node count: zero acts as one, clamp at the table size.
  always_comb begin
    if (node_count_i == '0) begin
      n_eff = NCNT_W'(1);
    end else if (int'(node_count_i) > MAX_NODES) begin
      n_eff = NCNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_i;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign oob = (cmd_e'(cmd_i) == CMD_LIST) ? ({1'b0, node_a_i} >= n_eff)
             : (({1'b0, node_a_i} >= n_eff) || ({1'b0, node_b_i} >= n_eff));

  // base(r) = r*n - r*(r+1)/2, products registered in ST_ADDR
  assign edit_idx = p1_q - (p2_q >> 1) + PROD_W'(c_q);

  // List walk: row/col is min/max of (a, k); base_q tracks base(min).
  assign col_max  = ({1'b0, r_q} > k_q) ? {1'b0, r_q} : k_q;
  assign list_idx = base_q + PROD_W'(col_max);
  assign k_end    = (k_q == n_eff - NCNT_W'(1));

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    r_d         = r_q;
    c_d         = c_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    base_d      = base_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_req_o   = '0;
    mem_addr_o  = '0;

    unique case (state_q)
      ST_CLR: begin
        mem_req_o  = '{en: 1'b1, we: 1'b1, wdata: 1'b0};
        mem_addr_o = clr_q;
        clr_d      = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_e'(cmd_i);
          if (oob) begin
            res_d   = '{status: 1'b1, found: 1'b0, neighbour: '0, last: 1'b1};
            state_d = ST_EMIT;
          end else if (cmd_e'(cmd_i) == CMD_LIST) begin
            r_d        = node_a_i;
            k_d        = '0;
            base_d     = '0;
            pend_d     = '0;
            pend_vld_d = 1'b0;
            cnt_d      = '0;
            state_d    = ST_LIST;
          end else begin
            r_d     = (node_a_i < node_b_i) ? node_a_i : node_b_i;
            c_d     = (node_a_i < node_b_i) ? node_b_i : node_a_i;
            state_d = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        p1_d    = PROD_W'(r_q) * PROD_W'(n_eff);
        p2_d    = PROD_W'(r_q) * (PROD_W'(r_q) + PROD_W'(1));
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        mem_addr_o = AW'(edit_idx);
        if (cmd_q == CMD_QUERY) begin
          mem_req_o = '{en: 1'b1, we: 1'b0, wdata: 1'b0};
          state_d   = ST_QRD;
        end else begin
          mem_req_o = '{en: 1'b1, we: 1'b1, wdata: (cmd_q == CMD_ADD)};
          res_d     = '{status: 1'b0, found: 1'b0, neighbour: '0, last: 1'b1};
          state_d   = ST_EMIT;
        end
      end
      ST_QRD: begin
        res_d   = '{status: 1'b0, found: mem_rdata_i, neighbour: '0, last: 1'b1};
        state_d = ST_EMIT;
      end
      ST_LIST: begin
        mem_req_o  = '{en: 1'b1, we: 1'b0, wdata: 1'b0};
        mem_addr_o = AW'(list_idx);
        state_d    = ST_LCHK;
      end
      ST_LCHK: begin
        // A held neighbour is sent only once a later one proves it is not last.
        if (!(mem_rdata_i && pend_vld_q && !out_free)) begin
          if (mem_rdata_i && pend_vld_q) begin
            out_valid_d = 1'b1;
            out_d = '{status: 1'b0, found: 1'b1, neighbour: pend_q, last: 1'b0};
          end
          if (mem_rdata_i) begin
            pend_d     = k_q[NODE_W-1:0];
            pend_vld_d = 1'b1;
            cnt_d      = cnt_q + CNT_W'(1);
          end
          if ((mem_rdata_i && (cnt_q == CNT_W'(RESULT_CAP - 1))) || k_end) begin
            res_d.status    = 1'b0;
            res_d.found     = mem_rdata_i || pend_vld_q;
            res_d.neighbour = mem_rdata_i ? k_q[NODE_W-1:0] : pend_q;
            res_d.last      = 1'b1;
            state_d         = ST_EMIT;
          end else begin
            if (k_q < {1'b0, r_q}) begin
              base_d = base_q + PROD_W'(n_eff - NCNT_W'(1) - k_q);
            end
            k_d     = k_q + NCNT_W'(1);
            state_d = ST_LIST;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    r_q        <= r_d;
    c_q        <= c_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    base_q     <= base_d;
    k_q        <= k_d;
    pend_q     <= pend_d;
    pend_vld_q <= pend_vld_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/undirected_adjacency_bit_table_core.sv =====
// Undirected adjacency bit table: one stored bit per unordered node pair.
// Input channel (in_valid_i / in_stall_o) takes one command item: add edge,
// remove edge, query edge or list the neighbours of node_a_i. Output channel
// (out_valid_o / out_stall_i) returns result items from an output register.
// Add/remove pass ST_ADDR, ST_EXEC and ST_EMIT, a query also ST_QRD; the index
// multiply and the single-port bit memory read/write set these steps. A list
// walks node_count pairs and emits one item per neighbour in ascending order
// (at most 64), the final one flagged last; an empty list gives one item with
// found low. A node at or above node_count (0 read as 1) returns status high.
// in_stall_o is high while an item is being worked on, and while a result waits
// on a stalled receiver only if the next result is already due.
// Reset: node_count returns to 64 and the bit memory is swept to zero, one bit
// per cycle, all MAX_NODES*(MAX_NODES+1)/2 bits (2080 at 64 nodes); input stays
// stalled until the sweep is done. node_count is written over the APB-style
// port at address 0 and must only change while the block is idle.
module undirected_adjacency_bit_table_core
  import uabt_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // command items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [NODE_W-1:0]  node_a_i,
  input  logic [NODE_W-1:0]  node_b_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic               found_o,
  output logic [NODE_W-1:0]  neighbour_o,
  output logic               last_o
);

  localparam int DEPTH = MAX_NODES * (MAX_NODES + 1) / 2;
  localparam int AW    = $clog2(DEPTH);

  logic [NCNT_W-1:0] node_count;
  mem_req_t          mem_req;
  logic [AW-1:0]     mem_addr;
  logic              mem_rdata;
  res_t              res;

  uabt_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .node_count_o (node_count)
  );

  // Sequencer: index math, list walk, clearing sweep, output register.
  uabt_ctrl #(
    .MAX_NODES (MAX_NODES),
    .DEPTH     (DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (res),
    .mem_req_o    (mem_req),
    .mem_addr_o   (mem_addr),
    .mem_rdata_i  (mem_rdata)
  );

  // Packed triangular bit store with a registered read port.
  uabt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .addr_i  (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign status_o    = res.status;
  assign found_o     = res.found;
  assign neighbour_o = res.neighbour;
  assign last_o      = res.last;

endmodule
